// ===== sv/wma_pkg.sv =====
// ----------------------------------------------------------------------------
// wma_pkg
// Shared types and constants for the windowed moving average core.
// ----------------------------------------------------------------------------
package wma_pkg;

	localparam int MAX_WINDOW_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int WINDOW_W        = 7;
	localparam int APB_ADDR_W      = 3;
	localparam int APB_DATA_W      = 32;

	// register index, taken from paddr[2]
	localparam logic REG_WINDOW_SIZE = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_ADJ,
		ST_DIV,
		ST_FIN
	} wma_state_t;

endpackage

// ===== sv/windowed_moving_average_core.sv =====
// ----------------------------------------------------------------------------
// windowed_moving_average_core: boxcar averager over a signed sample stream
// The core takes one request at a time: it captures the sample, prepares the sweep (ST_PREP),
// adjusts the running sum over the ring (ST_ADJ), runs a serial restoring divider (ST_DIV)
// and hands the result to the output register (ST_FIN). No new request is taken until the
// last one is through; a stalled result holds the core in its final state.
// Reset clears sum, fill count, pointer and window_size (to 1); the ring needs no clearing.
// ----------------------------------------------------------------------------
module windowed_moving_average_core #(
	parameter int MAX_WINDOW  = wma_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = wma_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// input stream
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// bits [SAMPLE_BITS-1:0]: sample, upper bits: zero padding
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,
	input  logic                                   s_axis_tlast,   // last_sample
	// result stream
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// bits [SAMPLE_BITS-1:0]: average, upper bits: zero padding
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]       m_axis_tdata,
	// configuration port
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [wma_pkg::APB_ADDR_W-1:0]         paddr,
	input  logic [wma_pkg::APB_DATA_W-1:0]         pwdata,
	output logic [wma_pkg::APB_DATA_W-1:0]         prdata,
	output logic                                   pready
);
	import wma_pkg::*;

	// Widths derived from the parameters.
	localparam int TW  = ((SAMPLE_BITS + 7) / 8) * 8;         // stream data width
	localparam int AW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;  // ring address
	localparam int NW  = $clog2(MAX_WINDOW + 1);              // counts 0..MAX_WINDOW
	localparam int SW  = SAMPLE_BITS + NW + 1;                // running sum, never wraps
	localparam int CW  = (NW > WINDOW_W) ? NW : WINDOW_W;     // window compare width
	localparam int DCW = $clog2(SW);                          // divider step counter

	// ------------------------------------------------------------------
	// Configuration register. Write it only while no request is in work;
	// each step reads it once, in ST_PREP.
	// ------------------------------------------------------------------
	logic [WINDOW_W-1:0] window_q;
	logic                cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WINDOW_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_W'(1);
		end else if (cfg_wr) begin
			window_q <= pwdata[WINDOW_W-1:0];
		end
	end

	// Read back the window register, zero for any other address.
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_WINDOW_SIZE) begin
			prdata = APB_DATA_W'(window_q);
		end
	end

	// ------------------------------------------------------------------
	// State machine and control strobes.
	// ------------------------------------------------------------------
	wma_state_t state_q, state_d;

	logic             s_fire;       // input request taken this cycle
	logic             adj_done;     // ring sweep finished, sum is final
	logic             out_load;     // move the quotient into the output register
	logic [NW-1:0]    cnt_q;        // ring reads still to issue
	logic             pend_q;       // ring read data lands this cycle
	logic [DCW-1:0]   div_cnt_q;
	logic             m_valid_q;

	assign s_fire   = s_axis_tvalid && s_axis_tready;
	assign adj_done = (cnt_q == '0) && !pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				state_d = ST_ADJ;
			end
			ST_ADJ: begin
				if (adj_done) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_cnt_q == '0) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				// hold the result until the output register frees up
				if (!m_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Sample ring: one synchronous memory, one write and one read port.
	// The new sample is written only after the sweep, so the slot it lands
	// in can still be read as the oldest sample leaving a full window.
	// ------------------------------------------------------------------
	logic signed [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
	logic signed [SAMPLE_BITS-1:0] rd_data_q;
	logic        [AW-1:0]          rd_ptr_q;
	logic                          ring_we;
	logic                          rd_issue;

	assign ring_we  = (state_q == ST_ADJ) && adj_done;
	assign rd_issue = (state_q == ST_ADJ) && (cnt_q != '0);

	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic                          last_q;
	logic        [AW-1:0]          slot_q;

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring[slot_q] <= sample_q;
		end
		if (rd_issue) begin
			rd_data_q <= ring[rd_ptr_q];
		end
	end

	// ------------------------------------------------------------------
	// Step preparation: new window length and the sweep that turns the
	// previous sum into the new one. With k counting back from the new
	// sample (k = 0), the old sum covers k = 1..n_prev and the new one
	// k = 0..n_new-1: add k = n_prev+1..n_new-1 or drop k = n_new..n_prev.
	// ------------------------------------------------------------------
	logic [NW-1:0]   fill_q;
	logic [NW-1:0]   n_prev_q;
	logic [NW-1:0]   n_q;
	logic            add_q;         // sweep adds (1) or drops (0) samples
	logic signed [SW-1:0] sum_q;

	logic [NW-1:0]   fill_next;
	logic [CW-1:0]   win_eff;
	logic [NW-1:0]   n_new;
	logic [NW-1:0]   n_m1;
	logic            grow;
	logic [NW-1:0]   k_start;
	logic [NW-1:0]   sweep_len;
	logic [NW:0]     base_ext;
	logic [NW:0]     start_ext;

	always_comb begin
		fill_next = (fill_q == NW'(MAX_WINDOW)) ? fill_q : fill_q + NW'(1);

		// zero window acts as one, oversized window saturates
		if (window_q == '0) begin
			win_eff = CW'(1);
		end else if (CW'(window_q) > CW'(MAX_WINDOW)) begin
			win_eff = CW'(MAX_WINDOW);
		end else begin
			win_eff = CW'(window_q);
		end

		n_new = (CW'(fill_next) < win_eff) ? fill_next : NW'(win_eff);
		n_m1  = n_new - NW'(1);
		grow  = (n_m1 > n_prev_q);

		if (grow) begin
			k_start   = n_prev_q + NW'(1);
			sweep_len = n_m1 - n_prev_q;
		end else begin
			k_start   = n_new;
			sweep_len = n_prev_q - n_m1;
		end

		// ring address of the sample k_start steps back, wrapped
		base_ext = (NW+1)'(slot_q);
		if ((NW+1)'(k_start) > base_ext) begin
			start_ext = base_ext + (NW+1)'(MAX_WINDOW) - (NW+1)'(k_start);
		end else begin
			start_ext = base_ext - (NW+1)'(k_start);
		end
	end

	// ------------------------------------------------------------------
	// Datapath: sweep, running sum, per-sequence state.
	// ------------------------------------------------------------------
	logic [SW-1:0]   quo_q;        // dividend shifts out, quotient shifts in
	logic [NW-1:0]   rem_q;
	logic            neg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			fill_q   <= '0;
			n_prev_q <= '0;
			slot_q   <= '0;
			cnt_q    <= '0;
			pend_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_PREP: begin
					sum_q <= sum_q + SW'(sample_q);
					cnt_q <= sweep_len;
				end
				ST_ADJ: begin
					pend_q <= rd_issue;
					if (rd_issue) begin
						cnt_q <= cnt_q - NW'(1);
					end
					if (pend_q) begin
						if (add_q) begin
							sum_q <= sum_q + SW'(rd_data_q);
						end else begin
							sum_q <= sum_q - SW'(rd_data_q);
						end
					end
					if (adj_done) begin
						// advance the sequence state, or clear it after the last sample
						if (last_q) begin
							sum_q    <= '0;
							fill_q   <= '0;
							n_prev_q <= '0;
							slot_q   <= '0;
						end else begin
							fill_q   <= fill_next;
							n_prev_q <= n_q;
							slot_q   <= (slot_q == AW'(MAX_WINDOW - 1)) ? '0
							            : slot_q + AW'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers: captured request, sweep pointer, divider.
	logic [NW:0] rem_try;

	assign rem_try = {rem_q, quo_q[SW-1]} - (NW+1)'(n_q);

	always_ff @(posedge clk) begin
		if (s_fire) begin
			sample_q <= s_axis_tdata[SAMPLE_BITS-1:0];
			last_q   <= s_axis_tlast;
		end
		case (state_q)
			ST_PREP: begin
				n_q      <= n_new;
				add_q    <= grow;
				rd_ptr_q <= AW'(start_ext);
			end
			ST_ADJ: begin
				if (rd_issue) begin
					rd_ptr_q <= (rd_ptr_q == '0) ? AW'(MAX_WINDOW - 1) : rd_ptr_q - AW'(1);
				end
				if (adj_done) begin
					// divide the magnitude, restore the sign afterwards
					neg_q     <= sum_q[SW-1];
					quo_q     <= sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
					rem_q     <= '0;
					div_cnt_q <= DCW'(SW - 1);
				end
			end
			ST_DIV: begin
				// one restoring step per cycle
				if (!rem_try[NW]) begin
					rem_q <= rem_try[NW-1:0];
				end else begin
					rem_q <= {rem_q[NW-2:0], quo_q[SW-1]};
				end
				quo_q     <= {quo_q[SW-2:0], !rem_try[NW]};
				div_cnt_q <= div_cnt_q - DCW'(1);
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Output register: parts the result side from the core.
	// ------------------------------------------------------------------
	logic [SW-1:0]          quo_signed;
	logic [TW-1:0]          m_data_q;

	assign quo_signed = neg_q ? (-quo_q) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= TW'(quo_signed[SAMPLE_BITS-1:0]);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

// ===== sv/wma_checker.sv =====
// ----------------------------------------------------------------------------
// wma_checker
// Port-level checks for the windowed moving average core, bound to the top.
// ----------------------------------------------------------------------------
module wma_checker #(
	parameter int SAMPLE_BITS = wma_pkg::SAMPLE_BITS_DEF
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_axis_tvalid,
	input logic                                s_axis_tready,
	input logic                                m_axis_tvalid,
	input logic                                m_axis_tready,
	input logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_axis_tdata,
	input logic                                pready
);
	import wma_pkg::*;

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// a stalled result keeps its data
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result data changed while stalled");

	// one request in work at a time
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second request taken while busy");

	// a new result only appears after the core was busy
	a_out_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result without a request in work");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind windowed_moving_average_core wma_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_wma_checker (.*);
